// File: src/plp_pkg.sv
// Package for the packed list block: request/response structs, request and
// status codes, output field widths.
// No dependencies.
package plp_pkg;

   localparam int DEFAULT_CAPACITY = 16;
   localparam int RESULT_LIMIT     = 16;
   localparam int DATA_W           = 32;

   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_DUMP   = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_EMPTY     = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [1:0]               req_type;
      logic signed [DATA_W-1:0] value;
   } plp_req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] entry_value;
      logic [3:0]               entry_index;
      logic [4:0]               removed_count;
      logic [4:0]               count;
      logic                     is_empty;
      logic                     is_full;
      logic                     is_single;
      logic                     last;
   } plp_rsp_type;

endpackage

// File: src/plp_store.sv
// Entry store for the packed list: one write port, one read port,
// registered read data. Uses plp_pkg for the data width.
module plp_store
   import plp_pkg::*;
#(
   parameter int DEPTH = DEFAULT_CAPACITY,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/packed_list_insert_remove.sv
// Packed list top level: request sequencer around the entry store.
// Depends on plp_pkg and plp_store.
//
// Requests are taken when start is high and busy is low. Insert, an
// unknown request type and any request on an empty list answer with one
// response in the cycle after the request and never raise busy. A remove
// walks the stored entries through the store's single read port, one
// entry per cycle, compacting in place, and answers after the last entry
// has been read and checked; busy drops in the response cycle. A dump of
// n entries (n = min(count, 16)) gives n responses on consecutive cycles,
// the first once entry 0 has been read from the store, the last marked by
// last. Responses cannot be held off; rsp_strobe marks each for one cycle.
module packed_list_insert_remove
   import plp_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  plp_req_type req_data,
   output logic        rsp_strobe,
   output plp_rsp_type rsp_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   typedef enum logic [1:0] {S_IDLE, S_REM, S_DUMP} state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     fill_ff, fill_in;
   logic [CW-1:0]     rd_idx_ff, rd_idx_in;
   logic [CW-1:0]     d_idx_ff, d_idx_in;
   logic [CW-1:0]     w_ff, w_in;
   logic [CW-1:0]     lim_ff, lim_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [DATA_W-1:0] val_ff, val_in;
   plp_rsp_type       rsp_ff, rsp_in;
   logic              rsp_strobe_ff, rsp_strobe_in;

   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [DATA_W-1:0] wr_data, rd_data;
   logic              keep, last_data;
   logic [CW-1:0]     new_fill;

   function automatic plp_rsp_type make_rsp(
      input logic [1:0]        status,
      input logic [DATA_W-1:0] ev,
      input logic [CW-1:0]     idx,
      input logic [CW-1:0]     removed,
      input logic [CW-1:0]     cnt,
      input logic              is_last
   );
      plp_rsp_type r;
      logic [31:0] idx_w, rem_w, cnt_w;
      idx_w           = 32'(idx);
      rem_w           = 32'(removed);
      cnt_w           = 32'(cnt);
      r.status        = status;
      r.entry_value   = ev;
      r.entry_index   = idx_w[3:0];
      r.removed_count = rem_w[4:0];
      r.count         = cnt_w[4:0];
      r.is_empty      = (cnt == '0);
      r.is_full       = (cnt == CAP_C);
      r.is_single     = (cnt == CW'(1));
      r.last          = is_last;
      return r;
   endfunction

   plp_store #(.DEPTH(CAPACITY)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Remove writes at w <= index of the entry being returned, always below
   // any later read address, so the store needs no forwarding.
   assign keep      = (rd_data != val_ff);
   assign last_data = ((d_idx_ff + CW'(1)) == lim_ff);
   assign new_fill  = keep ? (w_ff + CW'(1)) : w_ff;

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      rd_idx_in     = rd_idx_ff;
      d_idx_in      = d_idx_ff;
      w_in          = w_ff;
      lim_in        = lim_ff;
      rd_vld_in     = 1'b0;
      val_in        = val_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = fill_ff[AW-1:0];
      wr_data       = req_data.value;
      rd_en         = 1'b0;
      rd_addr       = rd_idx_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_strobe_in = 1'b1;
               rsp_in = make_rsp(ST_OK, '0, '0, '0, fill_ff, 1'b1);
               case (req_data.req_type)
                  REQ_INSERT: begin
                     if (fill_ff == CAP_C) begin
                        rsp_in = make_rsp(ST_FULL, '0, '0, '0, fill_ff, 1'b1);
                     end else begin
                        wr_en   = 1'b1;
                        fill_in = fill_ff + CW'(1);
                        rsp_in  = make_rsp(ST_OK, '0, '0, '0, fill_ff + CW'(1), 1'b1);
                     end
                  end
                  REQ_REMOVE, REQ_DUMP: begin
                     if (fill_ff == '0) begin
                        rsp_in = make_rsp(ST_EMPTY, '0, '0, '0, fill_ff, 1'b1);
                     end else begin
                        rsp_strobe_in = 1'b0;
                        val_in        = req_data.value;
                        rd_idx_in     = '0;
                        d_idx_in      = '0;
                        w_in          = '0;
                        if (req_data.req_type == REQ_REMOVE) begin
                           lim_in   = fill_ff;
                           state_in = S_REM;
                        end else begin
                           lim_in   = (32'(fill_ff) < RESULT_LIMIT) ? fill_ff
                                                                    : CW'(RESULT_LIMIT);
                           state_in = S_DUMP;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_REM, S_DUMP: begin
            if (rd_idx_ff < lim_ff) begin
               rd_en     = 1'b1;
               rd_vld_in = 1'b1;
               rd_idx_in = rd_idx_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               d_idx_in = d_idx_ff + CW'(1);
               if (state_ff == S_REM) begin
                  if (keep) begin
                     wr_en   = 1'b1;
                     wr_addr = w_ff[AW-1:0];
                     wr_data = rd_data;
                     w_in    = w_ff + CW'(1);
                  end
                  if (last_data) begin
                     fill_in       = new_fill;
                     rsp_strobe_in = 1'b1;
                     rsp_in        = make_rsp((new_fill == fill_ff) ? ST_NOT_FOUND : ST_OK,
                                              '0, '0, fill_ff - new_fill, new_fill, 1'b1);
                     state_in      = S_IDLE;
                  end
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_in        = make_rsp(ST_OK, rd_data, d_idx_ff, '0, fill_ff,
                                           last_data);
                  if (last_data) begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fill_ff       <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rd_idx_ff <= rd_idx_in;
      d_idx_ff  <= d_idx_in;
      w_ff      <= w_in;
      lim_ff    <= lim_in;
      val_ff    <= val_in;
      rsp_ff    <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CAP_C)
      else $error("fill count above capacity");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last |-> !busy)
      else $error("final response while still busy");

   a_dump_run: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |=> rsp_strobe)
      else $error("gap inside dump run");

   a_compact_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_REM && wr_en |-> w_ff <= d_idx_ff)
      else $error("compaction write ahead of read");

   a_accept_answer: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_strobe)
      else $error("request neither answered nor in progress");

endmodule
